>>> design/pzg_pkg.sv
// Shared types, constants and tables for the pinch zoom gesture tracker.
package pzg_pkg;

    localparam int CoordBits = 12;
    localparam int DiffW     = CoordBits + 1;
    localparam int DistW     = 2 * CoordBits + 1;
    localparam int CenterW   = CoordBits + 1;
    localparam int QuoW      = 48;
    localparam int ScaleW    = 24;
    localparam int ProdW     = 32;
    localparam int CordFrac  = 20;
    localparam int CordW     = CoordBits + CordFrac + 4;
    localparam int CordSteps = 20;
    localparam int ZW        = 25;
    localparam int AngW      = 16;
    localparam int LimitW    = 8;
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic [ScaleW-1:0] ScaleOne = ScaleW'(65536);
    localparam logic [ScaleW-1:0] ScaleMax = '1;
    localparam logic [ProdW-1:0]  ProdOne  = ProdW'(65536);
    localparam logic [LimitW-1:0] LimitReset = LimitW'(30);

    localparam logic REG_ROTATION_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        EV_BEGIN  = 2'd0,
        EV_UPDATE = 2'd1,
        EV_END    = 2'd2,
        EV_OTHER  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        GS_NONE    = 3'd0,
        GS_MAYBE   = 3'd1,
        GS_TRIGGER = 3'd2,
        GS_FINISH  = 3'd3,
        GS_CANCEL  = 3'd4,
        GS_IGNORE  = 3'd5
    } t_gesture;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_CUR,
        ST_DIST_LAST,
        ST_LAUNCH,
        ST_ANG_CUR,
        ST_ANG_ORG,
        ST_RATIO,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]           event_kind;
        logic [3:0]           point_count;
        logic [CoordBits-1:0] first_x;
        logic [CoordBits-1:0] first_y;
        logic [CoordBits-1:0] second_x;
        logic [CoordBits-1:0] second_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         gesture_state;
        logic [ScaleW-1:0]  previous_scale;
        logic [ScaleW-1:0]  step_scale;
        logic [ProdW-1:0]   overall_scale;
        logic [CenterW-1:0] origin_center_x;
        logic [CenterW-1:0] origin_center_y;
    } t_out_item;

    // Arctangent of 2^-i in degrees, Q.16.
    function automatic logic [ZW-2:0] atan_q16(input logic [4:0] idx);
        logic [ZW-2:0] v;
        case (idx)
            5'd0:    v = 24'd2949120;
            5'd1:    v = 24'd1740967;
            5'd2:    v = 24'd919879;
            5'd3:    v = 24'd466945;
            5'd4:    v = 24'd234379;
            5'd5:    v = 24'd117304;
            5'd6:    v = 24'd58666;
            5'd7:    v = 24'd29335;
            5'd8:    v = 24'd14668;
            5'd9:    v = 24'd7334;
            5'd10:   v = 24'd3667;
            5'd11:   v = 24'd1833;
            5'd12:   v = 24'd917;
            5'd13:   v = 24'd458;
            5'd14:   v = 24'd229;
            5'd15:   v = 24'd115;
            5'd16:   v = 24'd57;
            5'd17:   v = 24'd29;
            5'd18:   v = 24'd14;
            5'd19:   v = 24'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/pzg_divsqrt.sv
// Iterative distance ratio unit: restoring divide, then bitwise square root.
module pzg_divsqrt
    import pzg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DistW-1:0] i_num,
    input  logic [DistW-1:0] i_den,
    output logic             o_busy,
    output logic [ScaleW-1:0] o_root
);

    logic              r_busy;
    logic              r_sat;
    logic              r_sqrt;
    logic [5:0]        r_cnt;
    logic [DistW-1:0]  r_den;
    logic [DistW-1:0]  r_rem;
    logic [15:0]       r_low;
    logic [QuoW-1:0]   r_q;
    logic [QuoW-1:0]   r_res;
    logic [QuoW-1:0]   r_bit;

    logic [DistW:0]    trial;
    logic              ge;
    logic [QuoW-1:0]   sq_sum;
    logic              sq_ge;

    assign trial  = {r_rem, r_low[15]};
    assign ge     = trial >= {1'b0, r_den};
    assign sq_sum = r_res + r_bit;
    assign sq_ge  = r_q >= sq_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_sat || (r_sqrt && r_cnt == 6'd1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= (i_den == '0) ||
                      ({16'b0, i_num} >= {i_den, 16'b0});
            r_sqrt <= 1'b0;
            r_cnt  <= 6'd48;
            r_den  <= i_den;
            r_rem  <= DistW'(i_num >> 16);
            r_low  <= i_num[15:0];
            r_q    <= '0;
        end else if (r_busy) begin
            if (r_sat) begin
                r_res <= QuoW'(ScaleMax);
            end else if (!r_sqrt) begin
                // One quotient bit a cycle.
                r_rem <= ge ? DistW'(trial - {1'b0, r_den}) : DistW'(trial);
                r_q   <= {r_q[QuoW-2:0], ge};
                r_low <= {r_low[14:0], 1'b0};
                if (r_cnt == 6'd1) begin
                    r_sqrt <= 1'b1;
                    r_cnt  <= 6'd24;
                    r_res  <= '0;
                    r_bit  <= QuoW'(1) << (QuoW - 2);
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end else begin
                // One root bit a cycle.
                if (sq_ge) begin
                    r_q   <= r_q - sq_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[ScaleW-1:0];

endmodule

>>> design/pzg_cordic.sv
// Iterative vectoring CORDIC: angle of a point difference in Q9.7 degrees.
module pzg_cordic
    import pzg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DiffW-1:0] i_dx,
    input  logic signed [DiffW-1:0] i_dy,
    output logic                    o_busy,
    output logic signed [AngW-1:0]  o_angle
);

    logic                    r_busy;
    logic                    r_zero;
    logic                    r_neg;
    logic [4:0]              r_i;
    logic signed [CordW-1:0] r_x;
    logic signed [CordW-1:0] r_y;
    logic signed [ZW-1:0]    r_z;
    logic signed [AngW-1:0]  r_angle;

    logic [DiffW-1:0]        abs_dx;
    logic [DiffW-1:0]        abs_dy;
    logic signed [CordW-1:0] xs;
    logic signed [CordW-1:0] ys;
    logic signed [ZW-1:0]    tab;
    logic signed [ZW-1:0]    z_next;
    logic signed [ZW-1:0]    z_clip;
    logic signed [ZW-1:0]    z_round;

    assign abs_dx  = i_dx[DiffW-1] ? DiffW'(-i_dx) : DiffW'(i_dx);
    assign abs_dy  = i_dy[DiffW-1] ? DiffW'(-i_dy) : DiffW'(i_dy);
    assign xs      = r_x >>> r_i;
    assign ys      = r_y >>> r_i;
    assign tab     = $signed({1'b0, atan_q16(r_i)});
    assign z_next  = r_y[CordW-1] ? r_z - tab : r_z + tab;
    assign z_clip  = z_next[ZW-1] ? '0 : z_next;
    assign z_round = (z_clip + ZW'(256)) >>> 9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_i == 5'(CordSteps - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_dx == '0) || (i_dy == '0);
            r_neg  <= i_dx[DiffW-1] ^ i_dy[DiffW-1];
            r_i    <= '0;
            r_x    <= $signed(CordW'(abs_dy) << CordFrac);
            r_y    <= $signed(CordW'(abs_dx) << CordFrac);
            r_z    <= '0;
        end else if (r_busy) begin
            // Rotate toward the x axis.
            if (!r_y[CordW-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
            end
            r_z <= z_next;
            r_i <= r_i + 5'd1;
            if (r_i == 5'(CordSteps - 1)) begin
                if (r_zero) begin
                    r_angle <= '0;
                end else if (r_neg) begin
                    r_angle <= AngW'(-z_round);
                end else begin
                    r_angle <= AngW'(z_round);
                end
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_angle;

endmodule

>>> design/pinch_zoom_gesture_tracker_top.sv
// Top level of the pinch zoom gesture tracker: sequencer, gesture state, ports.
// Begin, end, other and non-pair update requests go from idle straight to commit.
// Two-point update: 3 setup states, 48-step divide + 24-step root with both 20-step
// CORDIC runs inside, idle check, multiply, commit; divide skipped if fresh, short if saturated.
// Throughput: one request at a time; ready again in the cycle in which the result becomes valid.
// Reset: synchronous active low; clears the gesture state, scales to one, limit to 30.
module pinch_zoom_gesture_tracker_top
    import pzg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    // Sequencer state.
    t_state r_state, n_state;

    // Request held while it is worked on.
    t_in_item r_in;

    // Gesture state.
    logic                 r_fresh;
    logic [CoordBits-1:0] r_org_ax, r_org_ay, r_org_bx, r_org_by;
    logic [CoordBits-1:0] r_rec_ax, r_rec_ay, r_rec_bx, r_rec_by;
    logic [CenterW-1:0]   r_center_x, r_center_y;
    logic [ScaleW-1:0]    r_scale_now, r_scale_before;
    logic [ProdW-1:0]     r_scale_prod;
    t_gesture             r_mode;
    logic [LimitW-1:0]    r_limit;
    logic                 r_out_valid;

    // Work registers.
    logic [DistW-1:0]            r_dist_cur, r_dist_last;
    logic signed [AngW-1:0]      r_ang_cur, r_ang_org;
    logic [ProdW+ScaleW-1:0]     r_prod;

    // Sequencer outputs.
    logic accept, out_free, commit;
    logic div_start, cord_start, cord_origin;
    logic pair_update;

    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign pair_update = (r_in.event_kind == EV_UPDATE) && (r_in.point_count == 4'd2);

    // Shared squarer: current pair or recent pair.
    logic signed [DiffW-1:0]   sq_dx, sq_dy;
    logic signed [2*DiffW-1:0] sq_xx, sq_yy;
    logic [DistW-1:0]          sq_sum;

    always_comb begin
        if (r_state == ST_DIST_CUR) begin
            sq_dx = $signed({1'b0, r_in.first_x}) - $signed({1'b0, r_in.second_x});
            sq_dy = $signed({1'b0, r_in.first_y}) - $signed({1'b0, r_in.second_y});
        end else begin
            sq_dx = $signed({1'b0, r_rec_ax}) - $signed({1'b0, r_rec_bx});
            sq_dy = $signed({1'b0, r_rec_ay}) - $signed({1'b0, r_rec_by});
        end
        sq_xx  = sq_dx * sq_dx;
        sq_yy  = sq_dy * sq_dy;
        sq_sum = DistW'(sq_xx) + DistW'(sq_yy);
    end

    // Angle operands: current pair first, then the origin pair.
    // A fresh sequence takes the current pair as its origin.
    logic [CoordBits-1:0]    org_ax, org_ay, org_bx, org_by;
    logic signed [DiffW-1:0] cord_dx, cord_dy;

    assign org_ax = r_fresh ? r_in.first_x  : r_org_ax;
    assign org_ay = r_fresh ? r_in.first_y  : r_org_ay;
    assign org_bx = r_fresh ? r_in.second_x : r_org_bx;
    assign org_by = r_fresh ? r_in.second_y : r_org_by;

    always_comb begin
        if (cord_origin) begin
            cord_dx = $signed({1'b0, org_ax}) - $signed({1'b0, org_bx});
            cord_dy = $signed({1'b0, org_ay}) - $signed({1'b0, org_by});
        end else begin
            cord_dx = $signed({1'b0, r_in.first_x}) - $signed({1'b0, r_in.second_x});
            cord_dy = $signed({1'b0, r_in.first_y}) - $signed({1'b0, r_in.second_y});
        end
    end

    logic                   div_busy, cord_busy;
    logic [ScaleW-1:0]      ratio;
    logic signed [AngW-1:0] cord_angle;

    pzg_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_dist_cur),
        .i_den   (r_dist_last),
        .o_busy  (div_busy),
        .o_root  (ratio)
    );

    pzg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_dx    (cord_dx),
        .i_dy    (cord_dy),
        .o_busy  (cord_busy),
        .o_angle (cord_angle)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_in_data.event_kind == EV_UPDATE) &&
                        (i_in_data.point_count == 4'd2)) begin
                        n_state = ST_DIST_CUR;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DIST_CUR:  n_state = ST_DIST_LAST;
            ST_DIST_LAST: n_state = ST_LAUNCH;
            ST_LAUNCH:    n_state = ST_ANG_CUR;
            ST_ANG_CUR: begin
                if (!cord_busy) n_state = ST_ANG_ORG;
            end
            ST_ANG_ORG: begin
                if (!cord_busy) n_state = ST_RATIO;
            end
            ST_RATIO: begin
                if (!div_busy) n_state = ST_MUL;
            end
            ST_MUL: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        div_start   = 1'b0;
        cord_start  = 1'b0;
        cord_origin = 1'b0;
        commit      = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_LAUNCH: begin
                cord_start = 1'b1;
                div_start  = !r_fresh;
            end
            ST_ANG_CUR: begin
                cord_origin = 1'b1;
                cord_start  = !cord_busy;
            end
            ST_FIN:  commit = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request and the intermediate results.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (r_state == ST_DIST_CUR) begin
            r_dist_cur <= sq_sum;
        end
        if (r_state == ST_DIST_LAST) begin
            r_dist_last <= sq_sum;
        end
        if (r_state == ST_ANG_CUR && !cord_busy) begin
            r_ang_cur <= cord_angle;
        end
        if (r_state == ST_ANG_ORG && !cord_busy) begin
            r_ang_org <= cord_angle;
        end
        if (r_state == ST_MUL) begin
            r_prod <= (r_fresh ? ProdOne : r_scale_prod) * (r_fresh ? ScaleOne : ratio);
        end
    end

    // Saturate the product and compare the rotation.
    logic [ProdW+ScaleW-17:0] prod_shift;
    logic [ProdW-1:0]         prod_sat;
    logic signed [AngW:0]     rot;
    logic signed [AngW:0]     lim;
    logic                     cancel;

    assign prod_shift = r_prod[ProdW+ScaleW-1:16];
    assign prod_sat   = (|prod_shift[ProdW+ScaleW-17:ProdW]) ? '1 : prod_shift[ProdW-1:0];
    assign rot        = (AngW+1)'(r_ang_org) - (AngW+1)'(r_ang_cur);
    assign lim        = $signed({2'b00, r_limit, 7'b0});
    assign cancel     = rot > lim;

    // Commit the step to the gesture state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh        <= 1'b1;
            r_org_ax       <= '0;
            r_org_ay       <= '0;
            r_org_bx       <= '0;
            r_org_by       <= '0;
            r_rec_ax       <= '0;
            r_rec_ay       <= '0;
            r_rec_bx       <= '0;
            r_rec_by       <= '0;
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_scale_now    <= ScaleOne;
            r_scale_before <= ScaleOne;
            r_scale_prod   <= ProdOne;
            r_mode         <= GS_NONE;
        end else if (commit) begin
            case (t_event'(r_in.event_kind))
                EV_BEGIN: r_mode <= GS_MAYBE;
                EV_UPDATE: begin
                    if (pair_update) begin
                        if (r_fresh) begin
                            r_org_ax       <= r_in.first_x;
                            r_org_ay       <= r_in.first_y;
                            r_org_bx       <= r_in.second_x;
                            r_org_by       <= r_in.second_y;
                            r_center_x     <= CenterW'(r_in.first_x) + CenterW'(r_in.second_x);
                            r_center_y     <= CenterW'(r_in.first_y) + CenterW'(r_in.second_y);
                            r_scale_now    <= ScaleOne;
                            r_scale_before <= ScaleOne;
                        end else begin
                            r_scale_before <= r_scale_now;
                            r_scale_now    <= ratio;
                        end
                        r_scale_prod <= prod_sat;
                        if (cancel) begin
                            r_mode <= GS_CANCEL;
                        end else begin
                            r_fresh <= 1'b0;
                            r_mode  <= GS_TRIGGER;
                        end
                        // A fresh sequence latches the pair even when it cancels.
                        if (r_fresh || !cancel) begin
                            r_rec_ax <= r_in.first_x;
                            r_rec_ay <= r_in.first_y;
                            r_rec_bx <= r_in.second_x;
                            r_rec_by <= r_in.second_y;
                        end
                    end else begin
                        // Lost the pair: restart the sequence.
                        r_fresh <= 1'b1;
                        r_mode  <= (r_mode == GS_NONE) ? GS_IGNORE : GS_FINISH;
                    end
                end
                EV_END: begin
                    r_mode <= (r_mode != GS_NONE && r_mode != GS_CANCEL) ?
                              GS_FINISH : GS_CANCEL;
                end
                default: ;
            endcase
        end
    end

    // Result slot: the state registers are the payload, frozen while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid                = r_out_valid;
    assign o_out_data.gesture_state   = r_mode;
    assign o_out_data.previous_scale  = r_scale_before;
    assign o_out_data.step_scale      = r_scale_now;
    assign o_out_data.overall_scale   = r_scale_prod;
    assign o_out_data.origin_center_x = r_center_x;
    assign o_out_data.origin_center_y = r_center_y;

    // Configuration port: one register, decoded on the word index.
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (cfg_write && paddr[2] == REG_ROTATION_LIMIT) begin
            r_limit <= pwdata[LimitW-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROTATION_LIMIT) ? DataW'(r_limit) : '0;
    assign pready = 1'b1;

endmodule

>>> design/pzg_checker.sv
// Port-level checker for the pinch zoom gesture tracker, bound to the top level.
module pzg_checker
    import pzg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new request taken while one is in work");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.gesture_state <= 3'd5))
        else $error("gesture state code out of range");

endmodule

bind pinch_zoom_gesture_tracker_top pzg_checker u_pzg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
